/* src/afr_pkg.sv */
package afr_pkg;

	localparam int RAW_W     = 12;
	localparam int PROD_W    = 20;
	localparam int BCD_DIGITS = 6;
	localparam int BCD_W     = BCD_DIGITS * 4;
	localparam int OUT_DIGITS = 4;
	localparam int CNT_W     = $clog2(PROD_W + 1);

	localparam logic [8:0] SCALE_NUM = 9'd391;
	localparam logic [6:0] ROUND_ADD = 7'd50;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	localparam logic [2:0] HEAD_LAST = 3'd5;

	typedef struct packed {
		logic              neg;
		logic [PROD_W-1:0] prod;
	} scaled_t;

	typedef struct packed {
		logic                      busy;
		logic [OUT_DIGITS-1:0][3:0] digits;
	} dab_status_t;

	function automatic logic [7:0] head_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = CH_DOLLAR;
			3'd1:    c = CH_M;
			3'd2:    c = CH_A;
			3'd3:    c = CH_C;
			3'd4:    c = CH_C;
			default: c = CH_COMMA;
		endcase
		return c;
	endfunction

endpackage

/* src/afr_in_if.sv */
interface afr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] x_low_byte;
	logic [7:0] x_high_byte;
	logic [7:0] y_low_byte;
	logic [7:0] y_high_byte;
	logic [7:0] z_low_byte;
	logic [7:0] z_high_byte;

	modport source (
		output valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
			z_low_byte, z_high_byte,
		input  ready
	);
	modport sink (
		input  valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
			z_low_byte, z_high_byte,
		output ready
	);
endinterface

/* src/afr_out_if.sv */
interface afr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (output valid, out_char, last_char, input ready);
	modport sink (input valid, out_char, last_char, output ready);
endinterface

/* src/afr_scale.sv */
module afr_scale (
	input  logic             clk,
	input  logic             load,
	input  logic [7:0]       lo,
	input  logic [7:0]       hi,
	output afr_pkg::scaled_t scaled
);
	import afr_pkg::*;

	logic [RAW_W-1:0]  raw;
	logic [RAW_W-1:0]  mag;
	logic [PROD_W-1:0] prod;
	scaled_t           scaled_q;

	assign raw  = {hi, lo[7:4]};
	// magnitude of -2048 is 2048, still fits as unsigned
	assign mag  = raw[RAW_W-1] ? (~raw + 1'b1) : raw;
	assign prod = PROD_W'(mag) * PROD_W'(SCALE_NUM) + PROD_W'(ROUND_ADD);

	always_ff @(posedge clk) begin
		if (load) begin
			scaled_q.neg  <= raw[RAW_W-1];
			scaled_q.prod <= prod;
		end
	end

	assign scaled = scaled_q;
endmodule

/* src/afr_dabble.sv */
module afr_dabble (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [afr_pkg::PROD_W-1:0] bin,
	output afr_pkg::dab_status_t      status
);
	import afr_pkg::*;

	logic [PROD_W-1:0] bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  adj;
	logic [CNT_W-1:0]  cnt_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
				: bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(PROD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bin_q <= {bin_q[PROD_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[PROD_W-1]};
		end
	end

	// dropping the two low decimal digits divides by 100
	assign status.busy   = (cnt_q != '0);
	assign status.digits = bcd_q[BCD_W-1:8];
endmodule

/* src/accel_sample_ascii_framer.sv */
// Takes one accelerometer burst (X, Y, Z low and high bytes) and sends the
// sentence "$MACC,x,y,z*" one ASCII byte per output transaction, each axis in
// milli-g as round(raw*391/100) with halves away from zero, a '-' for negative
// values, no leading zeros, and last_char set on the closing '*'. A sample runs
// from its input transaction to the last character through six header
// characters, then for each axis a 20-step bit-serial binary-to-BCD
// conversion followed by the sign when negative, four digit slots and the
// separator. The input is ready again once the closing '*' has been
// loaded into the output register.
module accel_sample_ascii_framer (
	input  logic      clk,
	input  logic      arst_n,
	afr_in_if.sink    sample,
	afr_out_if.source sentence
);
	import afr_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_HEAD  = 8'b0000_0010,
		ST_LOAD  = 8'b0000_0100,
		ST_START = 8'b0000_1000,
		ST_CONV  = 8'b0001_0000,
		ST_SIGN  = 8'b0010_0000,
		ST_DIGIT = 8'b0100_0000,
		ST_SEP   = 8'b1000_0000
	} state_t;

	state_t          state_q;
	logic [2:0]      pos_q;
	logic [1:0]      axis_q;
	logic [1:0]      idx_q;
	logic            lead_q;
	logic [2:0][7:0] lo_q;
	logic [2:0][7:0] hi_q;

	logic            out_v_q;
	logic [7:0]      char_q;
	logic            last_q;

	logic            take;
	logic            emit;
	logic [7:0]      emit_char;
	logic            emit_last;
	logic            skip;
	logic            scale_load;
	logic            conv_start;
	logic [3:0]      dig;
	scaled_t         scaled;
	dab_status_t     dab;

	afr_scale u_scale (
		.clk    (clk),
		.load   (scale_load),
		.lo     (lo_q[axis_q]),
		.hi     (hi_q[axis_q]),
		.scaled (scaled)
	);

	afr_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.bin    (scaled.prod),
		.status (dab)
	);

	assign take = !out_v_q || sentence.ready;
	assign dig  = dab.digits[idx_q];
	assign skip = lead_q && (dig == 4'd0) && (idx_q != 2'd0);

	assign sample.ready = (state_q == ST_IDLE);
	assign scale_load   = (state_q == ST_LOAD);
	assign conv_start   = (state_q == ST_START);

	always_comb begin
		emit      = 1'b0;
		emit_char = CH_ZERO;
		emit_last = 1'b0;
		unique case (state_q)
			ST_HEAD: begin
				emit      = take;
				emit_char = head_char(pos_q);
			end
			ST_SIGN: begin
				emit      = take;
				emit_char = CH_MINUS;
			end
			ST_DIGIT: begin
				emit      = take && !skip;
				emit_char = CH_ZERO | {4'd0, dig};
			end
			ST_SEP: begin
				emit      = take;
				emit_char = (axis_q == 2'd2) ? CH_STAR : CH_COMMA;
				emit_last = (axis_q == 2'd2);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			axis_q  <= '0;
			idx_q   <= '0;
			lead_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						pos_q   <= '0;
						axis_q  <= '0;
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					if (take) begin
						pos_q <= pos_q + 1'b1;
						if (pos_q == HEAD_LAST) begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (!dab.busy) begin
						idx_q   <= 2'(OUT_DIGITS - 1);
						lead_q  <= 1'b1;
						state_q <= scaled.neg ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					if (take) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					// leading zeros are dropped without a transaction
					if (skip) begin
						idx_q <= idx_q - 1'b1;
					end else if (take) begin
						lead_q <= 1'b0;
						if (idx_q == 2'd0) begin
							state_q <= ST_SEP;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				ST_SEP: begin
					if (take) begin
						if (axis_q == 2'd2) begin
							state_q <= ST_IDLE;
						end else begin
							axis_q  <= axis_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			lo_q <= {sample.z_low_byte, sample.y_low_byte, sample.x_low_byte};
			hi_q <= {sample.z_high_byte, sample.y_high_byte, sample.x_high_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (sentence.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign sentence.valid     = out_v_q;
	assign sentence.out_char  = char_q;
	assign sentence.last_char = last_q;
endmodule

/* src/afr_checker.sv */
module afr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       last_char
);
	import afr_pkg::*;

	// a stalled character holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_char))
		else $error("stalled output character changed");

	// one sample at a time
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a sample transaction");

	a_last_star: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_char |-> out_char == CH_STAR)
		else $error("last_char flagged on a character other than the asterisk");

	// no new character can be produced in the cycle a sample is taken
	a_no_emit_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid == $past(out_valid && !out_ready))
		else $error("character produced in the sample transaction cycle");
endmodule

bind accel_sample_ascii_framer afr_checker u_afr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (sentence.valid),
	.out_ready (sentence.ready),
	.out_char  (sentence.out_char),
	.last_char (sentence.last_char)
);

/* sim/tb_top.sv */
module tb_top;
	import afr_pkg::*;

	localparam int MG_NUM      = 391;
	localparam int MG_DEN      = 100;
	localparam int IDLE_PCT    = 37;
	localparam int RAND_BURSTS = 410;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 120;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} sent_char_t;

	class ascii_sentence_board;
		sent_char_t pending_chars[$];
		int         errors;

		function int milli_g(input logic [7:0] lo, input logic [7:0] hi);
			logic signed [11:0] raw;
			int mag;
			int q;
			raw = {hi, lo[7:4]};
			mag = (raw < 0) ? -int'(raw) : int'(raw);
			q = (mag * MG_NUM + MG_DEN / 2) / MG_DEN;
			return (raw < 0) ? -q : q;
		endfunction

		function void push_char(input logic [7:0] c, input logic last);
			sent_char_t e;
			e.ch = c;
			e.last = last;
			pending_chars.push_back(e);
		endfunction

		// decimal text with sign, no leading zeros, "0" for zero
		function void push_value(input int v);
			string s;
			s = $sformatf("%0d", v);
			for (int i = 0; i < s.len(); i++)
				push_char(s[i], 1'b0);
		endfunction

		function void add_sample(input logic [7:0] xl, input logic [7:0] xh,
				input logic [7:0] yl, input logic [7:0] yh,
				input logic [7:0] zl, input logic [7:0] zh);
			push_char(CH_DOLLAR, 1'b0);
			push_char(CH_M, 1'b0);
			push_char(CH_A, 1'b0);
			push_char(CH_C, 1'b0);
			push_char(CH_C, 1'b0);
			push_char(CH_COMMA, 1'b0);
			push_value(milli_g(xl, xh));
			push_char(CH_COMMA, 1'b0);
			push_value(milli_g(yl, yh));
			push_char(CH_COMMA, 1'b0);
			push_value(milli_g(zl, zh));
			push_char(CH_STAR, 1'b1);
		endfunction

		function void check_char(input logic [7:0] c, input logic last);
			sent_char_t e;
			if (pending_chars.size() == 0) begin
				$error("unexpected character %h (last_char %b)", c, last);
				errors++;
				return;
			end
			e = pending_chars.pop_front();
			if (c !== e.ch) begin
				$error("out_char expected %h actual %h", e.ch, c);
				errors++;
			end
			if (last !== e.last) begin
				$error("last_char expected %b actual %b", e.last, last);
				errors++;
			end
		endfunction

		function int pending_size();
			return pending_chars.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	bit   held_off;
	int   samples_taken;
	int   quiet_cycles;

	ascii_sentence_board board = new();

	afr_in_if  sample_if();
	afr_out_if sentence_if();

	accel_sample_ascii_framer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_if),
		.sentence (sentence_if)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// transaction monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_if.valid && sample_if.ready) begin
				board.add_sample(sample_if.x_low_byte, sample_if.x_high_byte,
					sample_if.y_low_byte, sample_if.y_high_byte,
					sample_if.z_low_byte, sample_if.z_high_byte);
				samples_taken++;
			end
			if (sentence_if.valid && sentence_if.ready)
				board.check_char(sentence_if.out_char, sentence_if.last_char);
			if ((sample_if.valid && sample_if.ready) ||
					(sentence_if.valid && sentence_if.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("[accel_sample_ascii_framer] ERROR");
					$finish;
				end
			end
		end
	end

	// receiver: random stalls, ready throughout the steady phase, one long hold-off to back up the input
	initial begin
		sentence_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				sentence_if.ready = 1'b0;
			end else if (!held_off && samples_taken >= 60) begin
				held_off = 1'b1;
				sentence_if.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (steady) begin
				sentence_if.ready = 1'b1;
			end else begin
				sentence_if.ready = ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_burst(input logic [7:0] xl, input logic [7:0] xh,
			input logic [7:0] yl, input logic [7:0] yh,
			input logic [7:0] zl, input logic [7:0] zh);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			sample_if.valid = 1'b0;
			@(negedge clk);
		end
		sample_if.valid = 1'b1;
		sample_if.x_low_byte = xl;
		sample_if.x_high_byte = xh;
		sample_if.y_low_byte = yl;
		sample_if.y_high_byte = yh;
		sample_if.z_low_byte = zl;
		sample_if.z_high_byte = zh;
		do @(posedge clk); while (!sample_if.ready);
	endtask

	// mix of full-range, near-zero and near-limit samples
	task automatic pick_axis(output logic [7:0] lo, output logic [7:0] hi);
		logic [7:0] edges [6];
		edges = '{8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01, 8'hFE};
		lo = 8'($urandom);
		case ($urandom_range(3))
			2:       hi = $urandom_range(1) ? 8'h00 : 8'hFF;
			3:       hi = edges[$urandom_range(5)];
			default: hi = 8'($urandom);
		endcase
	endtask

	logic [47:0] directed [12] = '{
		48'h00_00_00_00_00_00,
		48'h00_80_00_80_00_80,
		48'hF0_7F_F0_7F_F0_7F,
		48'h0F_00_0F_80_0F_7F,
		48'hF0_FF_10_00_00_00,
		48'h20_03_E0_FC_30_00,
		48'hA0_01_00_10_00_F0,
		48'hFF_7F_0F_80_FF_FF,
		48'hD0_FF_90_01_60_FE,
		48'h5A_00_A5_FF_3C_7F,
		48'hFF_FF_FF_FF_FF_FF,
		48'h70_80_8F_7F_00_00
	};

	initial begin
		logic [7:0] xl, xh, yl, yh, zl, zh;
		arst_n = 1'b0;
		steady = 1'b0;
		sample_if.valid = 1'b0;
		sample_if.x_low_byte = '0;
		sample_if.x_high_byte = '0;
		sample_if.y_low_byte = '0;
		sample_if.y_high_byte = '0;
		sample_if.z_low_byte = '0;
		sample_if.z_high_byte = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_burst(directed[i][47:40], directed[i][39:32], directed[i][31:24],
				directed[i][23:16], directed[i][15:8], directed[i][7:0]);

		for (int n = 0; n < RAND_BURSTS; n++) begin
			steady = (n >= 200 && n < 300);
			pick_axis(xl, xh);
			pick_axis(yl, yh);
			pick_axis(zl, zh);
			send_burst(xl, xh, yl, yh, zl, zh);
		end
		@(negedge clk);
		sample_if.valid = 1'b0;
		steady = 1'b0;

		while (board.pending_size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (board.errors == 0)
			$display("[accel_sample_ascii_framer] OK");
		else
			$display("[accel_sample_ascii_framer] ERROR");
		$finish;
	end

endmodule
